// ----- sv/bitmap_index_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// bitmap_index_allocator_macros.svh
// Assertion macros shared by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_INDEX_ALLOCATOR_MACROS_SVH
`define BITMAP_INDEX_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BIA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define BIA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- sv/bia_pkg.sv -----
// ----------------------------------------------------------------------------
// bia_pkg
// Types and constants of the bitmap index allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int WORD_W   = 32;  // map bits per memory row
  localparam int BIT_W    = 5;   // bit position within a row
  localparam int INDEX_W  = 10;
  localparam int GRANT_W  = 10;
  localparam int SIZE_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOT_HELD = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_UPD
  } state_e;

endpackage

// ----- sv/bia_ffs.sv -----
// ----------------------------------------------------------------------------
// bia_ffs
// Lowest-set-bit finder over one 32-bit word; shared by summary scan and
// row update.
// ----------------------------------------------------------------------------
module bia_ffs (
  input  logic [bia_pkg::WORD_W-1:0] word_i,
  output logic                       found_o,
  output logic [bia_pkg::BIT_W-1:0]  pos_o
);

  always_comb begin
    found_o = |word_i;
    pos_o   = '0;
    for (int b = bia_pkg::WORD_W - 1; b >= 0; b--) begin
      if (word_i[b]) begin
        pos_o = bia_pkg::BIT_W'(b);
      end
    end
  end

endmodule

// ----- sv/bia_map_mem.sv -----
// ----------------------------------------------------------------------------
// bia_map_mem
// Free map storage: one row of 32 free bits per address, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bia_map_mem #(
  parameter int ROWS  = 32,
  parameter int ROW_W = 5
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ROW_W-1:0]           waddr_i,
  input  logic [bia_pkg::WORD_W-1:0] wdata_i,
  input  logic [ROW_W-1:0]           raddr_i,
  output logic [bia_pkg::WORD_W-1:0] rdata_o
);

  logic [bia_pkg::WORD_W-1:0] mem [ROWS];
  logic [bia_pkg::WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bitmap_index_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_index_allocator
// Lowest-first index allocator over a bitmap of free bits.
// ----------------------------------------------------------------------------
// Use: raise start with mode_i/index_i; the request is taken at a clock edge
// where start is high and busy is low. mode_i = allocate returns the lowest
// free index, mode_i = free returns index_i to the pool. Each request gives
// exactly one result beat on granted_index_o/status_o, marked by done_o for
// one cycle; the receiver cannot stall it.
// Steps: a free in range reads its map row as it is taken and updates it in
// S_UPD, which sets the registered done_o; a free out of range is answered
// from the idle state. An allocate scans the summary in S_SCAN, one 32-row
// chunk at a time (1 to ceil(ENTRIES/1024) chunks), reads the row found and
// claims its lowest free bit in S_UPD; an empty pool reports after all
// chunks. One request is in work at a time; busy drops as the result beat
// shows, so the next request can be taken in that cycle. The shared
// find-first unit serves one summary chunk, then one map row, and the read
// of the map memory is registered. Reset and every pool_size write start an
// init sweep that writes one map row per cycle with busy high; afterwards
// indices 1..pool_size-1 are free and index 0 is held.
// ----------------------------------------------------------------------------
module bitmap_index_allocator #(
  parameter int ENTRIES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode_i,
  input  logic [bia_pkg::INDEX_W-1:0]  index_i,
  input  logic                         pool_size_we_i,
  input  logic [bia_pkg::SIZE_W-1:0]   pool_size_i,
  output logic                         done_o,
  output logic [bia_pkg::GRANT_W-1:0]  granted_index_o,
  output logic [bia_pkg::STATUS_W-1:0] status_o
);

  localparam int WW        = bia_pkg::WORD_W;
  localparam int BW        = bia_pkg::BIT_W;
  localparam int ROWS      = (ENTRIES + WW - 1) / WW;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CHUNKS    = (ROWS + WW - 1) / WW;
  localparam int CHK_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int SUM_W     = CHUNKS * WW;
  localparam int SUM_IDX_W = $clog2(SUM_W);
  localparam int RF_W      = CHK_W + BW;
  localparam int GI_W      = ROW_W + BW;
  localparam int CW        = ((GI_W > bia_pkg::SIZE_W) ? GI_W : bia_pkg::SIZE_W) + 1;
  localparam int RST_SIZE  = (ENTRIES < 1024) ? ENTRIES : 1024;

  bia_pkg::state_e state_q, state_d;
  logic [ROW_W-1:0]            row_q, row_d;
  logic [BW-1:0]               bit_q, bit_d;
  logic                        op_q, op_d;
  logic [CHK_W-1:0]            chk_q, chk_d;
  logic [bia_pkg::SIZE_W-1:0]  size_q, size_d;
  logic [SUM_W-1:0]            summary_q, summary_d;
  logic                        done_q, done_d;
  logic [bia_pkg::GRANT_W-1:0] granted_q, granted_d;
  bia_pkg::status_e            status_q, status_d;

  // shared find-first unit
  logic [WW-1:0] ffs_word;
  logic          ffs_found;
  logic [BW-1:0] ffs_pos;

  // map memory port
  logic          mem_we;
  logic [ROW_W-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_rdata;

  logic [WW-1:0]   chunk_word;
  logic [RF_W-1:0] scan_row;
  logic [GI_W-1:0] req_idx;
  logic            req_range;
  logic [bia_pkg::SIZE_W-1:0] cfg_size;
  logic [GI_W-1:0] init_lo;
  logic [CW-1:0]   init_diff;
  logic [WW-1:0]   init_word;
  logic [WW-1:0]   upd_free_word, upd_alloc_word;
  logic            last_row, last_chk;

  bia_ffs u_ffs (
    .word_i  (ffs_word),
    .found_o (ffs_found),
    .pos_o   (ffs_pos)
  );

  bia_map_mem #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign chunk_word = summary_q[chk_q*WW +: WW];
  assign ffs_word   = (state_q == bia_pkg::S_SCAN) ? chunk_word : mem_rdata;
  assign scan_row   = {chk_q, ffs_pos};
  assign req_idx    = GI_W'(index_i);
  assign req_range  = bia_pkg::SIZE_W'(index_i) >= size_q;
  assign last_row   = row_q == ROW_W'(ROWS - 1);
  assign last_chk   = chk_q == CHK_W'(CHUNKS - 1);

  // clamp of a written pool size to 1..ENTRIES
  always_comb begin
    cfg_size = pool_size_i;
    if (pool_size_i == '0) begin
      cfg_size = bia_pkg::SIZE_W'(1);
    end else if (int'(pool_size_i) > ENTRIES) begin
      cfg_size = bia_pkg::SIZE_W'(ENTRIES);
    end
  end

  // init row: bits lo..size-1 set, bit 0 of row 0 held
  always_comb begin
    init_lo   = {row_q, BW'(0)};
    init_diff = CW'(size_q) - CW'(init_lo);
    if (init_diff[CW-1] || init_diff == '0) begin
      init_word = '0;
    end else if (init_diff >= CW'(WW)) begin
      init_word = '1;
    end else begin
      init_word = ~({WW{1'b1}} << init_diff[BW-1:0]);
    end
    if (row_q == '0) begin
      init_word[0] = 1'b0;
    end
  end

  always_comb begin
    upd_free_word           = mem_rdata;
    upd_free_word[bit_q]    = 1'b1;
    upd_alloc_word          = mem_rdata;
    upd_alloc_word[ffs_pos] = 1'b0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bia_pkg::S_INIT: begin
        if (last_row) state_d = bia_pkg::S_IDLE;
      end
      bia_pkg::S_IDLE: begin
        if (start) begin
          if (mode_i == bia_pkg::MODE_ALLOC) begin
            state_d = bia_pkg::S_SCAN;
          end else if (!req_range) begin
            state_d = bia_pkg::S_UPD;
          end
        end
      end
      bia_pkg::S_SCAN: begin
        if (ffs_found) begin
          state_d = bia_pkg::S_UPD;
        end else if (last_chk) begin
          state_d = bia_pkg::S_IDLE;
        end
      end
      bia_pkg::S_UPD: state_d = bia_pkg::S_IDLE;
      default:        state_d = bia_pkg::S_INIT;
    endcase
    if (pool_size_we_i) state_d = bia_pkg::S_INIT;
  end

  // datapath and outputs
  always_comb begin
    row_d     = row_q;
    bit_d     = bit_q;
    op_d      = op_q;
    chk_d     = chk_q;
    size_d    = size_q;
    summary_d = summary_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = init_word;
    mem_raddr = row_q;
    unique case (state_q)
      bia_pkg::S_INIT: begin
        mem_we = 1'b1;
        summary_d[SUM_IDX_W'(row_q)] = |init_word;
        row_d = last_row ? '0 : row_q + 1'b1;
      end
      bia_pkg::S_IDLE: begin
        if (start) begin
          op_d  = mode_i;
          chk_d = '0;
          row_d = req_idx[GI_W-1:BW];
          bit_d = req_idx[BW-1:0];
          mem_raddr = req_idx[GI_W-1:BW];
          if (mode_i == bia_pkg::MODE_FREE && req_range) begin
            done_d    = 1'b1;
            granted_d = '0;
            status_d  = bia_pkg::ST_RANGE;
          end
        end
      end
      bia_pkg::S_SCAN: begin
        mem_raddr = scan_row[ROW_W-1:0];
        row_d     = scan_row[ROW_W-1:0];
        if (!ffs_found) begin
          chk_d = chk_q + 1'b1;
          if (last_chk) begin
            done_d    = 1'b1;
            granted_d = '0;
            status_d  = bia_pkg::ST_EMPTY;
          end
        end
      end
      bia_pkg::S_UPD: begin
        done_d = 1'b1;
        if (op_q == bia_pkg::MODE_ALLOC) begin
          // summary says this row has a free bit
          mem_we    = 1'b1;
          mem_wdata = upd_alloc_word;
          summary_d[SUM_IDX_W'(row_q)] = |upd_alloc_word;
          granted_d = bia_pkg::GRANT_W'({row_q, ffs_pos});
          status_d  = bia_pkg::ST_OK;
        end else begin
          granted_d = '0;
          if (mem_rdata[bit_q]) begin
            status_d = bia_pkg::ST_NOT_HELD;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = upd_free_word;
            summary_d[SUM_IDX_W'(row_q)] = 1'b1;
            status_d  = bia_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
    if (pool_size_we_i) begin
      size_d = cfg_size;
      row_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bia_pkg::S_INIT;
      row_q     <= '0;
      size_q    <= bia_pkg::SIZE_W'(RST_SIZE);
      summary_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      size_q    <= size_d;
      summary_q <= summary_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q     <= bit_d;
    op_q      <= op_d;
    chk_q     <= chk_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign busy            = state_q != bia_pkg::S_IDLE;
  assign done_o          = done_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;

endmodule

// ----- sv/bia_checker.sv -----
// ----------------------------------------------------------------------------
// bia_checker
// Port-level checks of the bitmap index allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_index_allocator_macros.svh"

module bia_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         pool_size_we_i,
  input logic                         done_o,
  input logic [bia_pkg::GRANT_W-1:0]  granted_index_o,
  input logic [bia_pkg::STATUS_W-1:0] status_o
);

  // a taken request either starts work or answers at once
  `BIA_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_o)

  // a size write always kicks off the init sweep
  `BIA_ASSERT_NXT(a_cfg_sweep, pool_size_we_i, busy)

  // failed beats never carry an index
  `BIA_ASSERT_IMP(a_fail_zero, done_o && status_o != bia_pkg::ST_OK, granted_index_o == '0)

  // a result beat leaves the block ready
  `BIA_ASSERT_IMP(a_done_idle, done_o && !$past(pool_size_we_i), !busy)

endmodule

bind bitmap_index_allocator bia_checker u_bia_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .pool_size_we_i  (pool_size_we_i),
  .done_o          (done_o),
  .granted_index_o (granted_index_o),
  .status_o        (status_o)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bitmap_index_allocator. A directed table covers
// reset state, the pool size extremes and every status code. Random phases
// at different pool sizes follow, mostly allocates and frees of indices in
// use, with some stray frees. Each result beat is checked against a local
// model of the free bitmap or against a directed row's typed-in expectation.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES      = 1024;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 100;
  localparam int QUIET_FROM   = 850;

  typedef enum bit [1:0] {
    ROW_ALLOC,
    ROW_FREE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    logic [bia_pkg::GRANT_W-1:0] granted;
    bia_pkg::status_e            status;
  } alloc_beat_t;

  typedef struct {
    row_kind_e                   kind;
    int unsigned                 value;    // index to free, or pool size to write
    bit                          fixed;
    logic [bia_pkg::GRANT_W-1:0] granted;
    bia_pkg::status_e            status;
  } stim_row_t;

  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic                         mode_i         = bia_pkg::MODE_ALLOC;
  logic [bia_pkg::INDEX_W-1:0]  index_i        = '0;
  logic                         pool_size_we_i = 1'b0;
  logic [bia_pkg::SIZE_W-1:0]   pool_size_i    = '0;
  logic                         done_o;
  logic [bia_pkg::GRANT_W-1:0]  granted_index_o;
  logic [bia_pkg::STATUS_W-1:0] status_o;

  // typed-in expectation riding along with the request beat
  bit                          row_fixed   = 1'b0;
  logic [bia_pkg::GRANT_W-1:0] row_granted = '0;
  bia_pkg::status_e            row_status  = bia_pkg::ST_OK;

  logic [ENTRIES-1:0] free_bits;
  int unsigned        pool_limit;
  alloc_beat_t        pending_beats[$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count    = 0;

  bitmap_index_allocator #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .index_i        (index_i),
    .pool_size_we_i (pool_size_we_i),
    .pool_size_i    (pool_size_i),
    .done_o         (done_o),
    .granted_index_o(granted_index_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic void load_free_bits(input logic [bia_pkg::SIZE_W-1:0] value);
    int unsigned size;
    size = value;
    if (size == 0) size = 1;
    if (size > ENTRIES) size = ENTRIES;
    pool_limit = size;
    free_bits = '0;
    for (int unsigned i = 1; i < size; i++) free_bits[i] = 1'b1;
  endfunction

  function automatic alloc_beat_t allocate_or_free(input logic mode,
                                                   input logic [bia_pkg::INDEX_W-1:0] idx);
    alloc_beat_t beat;
    beat.granted = '0;
    beat.status  = bia_pkg::ST_OK;
    if (mode == bia_pkg::MODE_ALLOC) begin
      beat.status = bia_pkg::ST_EMPTY;
      for (int unsigned i = 0; i < pool_limit; i++) begin
        if (free_bits[i]) begin
          free_bits[i] = 1'b0;
          beat.granted = i[bia_pkg::GRANT_W-1:0];
          beat.status  = bia_pkg::ST_OK;
          break;
        end
      end
    end else if (idx >= pool_limit) begin
      beat.status = bia_pkg::ST_RANGE;
    end else if (free_bits[idx]) begin
      beat.status = bia_pkg::ST_NOT_HELD;
    end else begin
      free_bits[idx] = 1'b1;
    end
    return beat;
  endfunction

  // result check, then config and request tracking, all on pre-edge values
  always @(posedge clk_i or negedge rst_ni) begin : track_beats
    alloc_beat_t want;
    alloc_beat_t model_beat;
    if (!rst_ni) begin
      load_free_bits(bia_pkg::SIZE_W'(ENTRIES));
      pending_beats.delete();
    end else begin
      if (done_o) begin
        if (pending_beats.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat granted_index %0d status %0d",
                   $time, granted_index_o, status_o);
        end else begin
          want = pending_beats.pop_front();
          if (granted_index_o !== want.granted) begin
            mismatch_count++;
            $display("%0t: granted_index expected %0d got %0d",
                     $time, want.granted, granted_index_o);
          end
          if (status_o !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d got %0d",
                     $time, want.status, status_o);
          end
        end
      end
      if (pool_size_we_i) load_free_bits(pool_size_i);
      if (start && !busy) begin
        model_beat = allocate_or_free(mode_i, index_i);
        if (row_fixed) begin
          want.granted = row_granted;
          want.status  = row_status;
          pending_beats.push_back(want);
        end else begin
          pending_beats.push_back(model_beat);
        end
      end
    end
  end

  // entered and left at a rising edge; returns at the accepting edge
  task automatic send_request(input logic mode, input logic [bia_pkg::INDEX_W-1:0] idx,
                              input bit fixed, input logic [bia_pkg::GRANT_W-1:0] granted,
                              input bia_pkg::status_e status);
    start       <= 1'b1;
    mode_i      <= mode;
    index_i     <= idx;
    row_fixed   <= fixed;
    row_granted <= granted;
    row_status  <= status;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_beats.size() != 0 || busy);
    @(posedge clk_i);
  endtask

  task automatic write_pool_size(input logic [bia_pkg::SIZE_W-1:0] value);
    wait_drained();
    pool_size_we_i <= 1'b1;
    pool_size_i    <= value;
    @(posedge clk_i);
    pool_size_we_i <= 1'b0;
    // let the init sweep raise busy before the next request
    repeat (2) @(posedge clk_i);
  endtask

  // an index currently in use, or a free one if none is held
  function automatic logic [bia_pkg::INDEX_W-1:0] pick_held_index();
    int unsigned first;
    int unsigned k;
    first = $urandom_range(pool_limit - 1, 0);
    for (int unsigned j = 0; j < pool_limit; j++) begin
      k = (first + j) % pool_limit;
      if (!free_bits[k]) return k[bia_pkg::INDEX_W-1:0];
    end
    return first[bia_pkg::INDEX_W-1:0];
  endfunction

  stim_row_t directed_rows [27] = '{
    '{ROW_ALLOC, 0,    1'b1, 10'd1, bia_pkg::ST_OK},
    '{ROW_ALLOC, 0,    1'b1, 10'd2, bia_pkg::ST_OK},
    '{ROW_FREE,  1,    1'b1, 10'd0, bia_pkg::ST_OK},
    '{ROW_ALLOC, 0,    1'b1, 10'd1, bia_pkg::ST_OK},
    '{ROW_FREE,  1,    1'b1, 10'd0, bia_pkg::ST_OK},
    '{ROW_FREE,  1,    1'b1, 10'd0, bia_pkg::ST_NOT_HELD},
    '{ROW_FREE,  0,    1'b1, 10'd0, bia_pkg::ST_OK},        // index 0 is ordinary on free
    '{ROW_ALLOC, 0,    1'b1, 10'd0, bia_pkg::ST_OK},
    '{ROW_FREE,  1023, 1'b1, 10'd0, bia_pkg::ST_NOT_HELD},
    '{ROW_FREE,  2,    1'b1, 10'd0, bia_pkg::ST_OK},
    '{ROW_CFG,   0,    1'b0, 10'd0, bia_pkg::ST_OK},        // zero size taken as one
    '{ROW_ALLOC, 0,    1'b1, 10'd0, bia_pkg::ST_EMPTY},
    '{ROW_FREE,  1,    1'b1, 10'd0, bia_pkg::ST_RANGE},
    '{ROW_FREE,  1023, 1'b1, 10'd0, bia_pkg::ST_RANGE},
    '{ROW_FREE,  0,    1'b1, 10'd0, bia_pkg::ST_OK},
    '{ROW_ALLOC, 0,    1'b1, 10'd0, bia_pkg::ST_OK},
    '{ROW_CFG,   2047, 1'b0, 10'd0, bia_pkg::ST_OK},        // clamps to ENTRIES
    '{ROW_ALLOC, 0,    1'b1, 10'd1, bia_pkg::ST_OK},
    '{ROW_FREE,  1023, 1'b1, 10'd0, bia_pkg::ST_NOT_HELD},
    '{ROW_CFG,   2,    1'b0, 10'd0, bia_pkg::ST_OK},
    '{ROW_ALLOC, 0,    1'b1, 10'd1, bia_pkg::ST_OK},
    '{ROW_ALLOC, 0,    1'b1, 10'd0, bia_pkg::ST_EMPTY},
    '{ROW_FREE,  2,    1'b1, 10'd0, bia_pkg::ST_RANGE},
    '{ROW_FREE,  1,    1'b1, 10'd0, bia_pkg::ST_OK},
    '{ROW_CFG,   1024, 1'b0, 10'd0, bia_pkg::ST_OK},
    '{ROW_ALLOC, 0,    1'b0, 10'd0, bia_pkg::ST_OK},
    '{ROW_FREE,  512,  1'b1, 10'd0, bia_pkg::ST_NOT_HELD}
  };

  initial begin : stimulus
    int unsigned phase_sizes [PHASES];
    int unsigned items_sent;
    int unsigned alloc_pct;
    int unsigned idle_pct;
    int unsigned pick;
    logic [bia_pkg::INDEX_W-1:0] idx;

    phase_sizes = '{1024, 1, 2, 33, 32, 5, 0, 2047, 0, 0};
    phase_sizes[8] = $urandom_range(1024, 1);
    phase_sizes[9] = $urandom_range(2047, 0);
    items_sent = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_pool_size(directed_rows[r].value[bia_pkg::SIZE_W-1:0]);
      end else begin
        send_request(directed_rows[r].kind == ROW_FREE ? bia_pkg::MODE_FREE
                                                       : bia_pkg::MODE_ALLOC,
                     directed_rows[r].value[bia_pkg::INDEX_W-1:0], directed_rows[r].fixed,
                     directed_rows[r].granted, directed_rows[r].status);
        items_sent++;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_pool_size(phase_sizes[p][bia_pkg::SIZE_W-1:0]);
      alloc_pct = $urandom_range(65, 35);
      idle_pct  = (p % 3 == 1) ? 0 : $urandom_range(40, 10);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
        if (items_sent < QUIET_FROM && $urandom_range(99) < idle_pct)
          hold_off($urandom_range(3, 1));
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
          send_request(bia_pkg::MODE_ALLOC, bia_pkg::INDEX_W'($urandom), 1'b0, '0,
                       bia_pkg::ST_OK);
        end else begin
          if (pick < 88) idx = pick_held_index();
          else idx = bia_pkg::INDEX_W'($urandom_range(1023, 0));
          send_request(bia_pkg::MODE_FREE, idx, 1'b0, '0, bia_pkg::ST_OK);
        end
        items_sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
